### rtl/sva_pkg.sv
// ----------------------------------------------------------------------------
// sva_pkg: shared types and constants of the voice allocator
// Request codes, status codes, defaults and the note frequency table.
// ----------------------------------------------------------------------------
package sva_pkg;

  localparam int VOICES_DEF   = 8;
  localparam int CHANNELS_DEF = 16;
  localparam int MAX_VEL_DEF  = 127;
  localparam logic [15:0] RELEASE_MS_RST = 16'd200;

  typedef enum logic [1:0] {
    REQ_NOTE_ON  = 2'd0,
    REQ_NOTE_OFF = 2'd1,
    REQ_ALL_OFF  = 2'd2,
    REQ_UPDATE   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_REJECT = 2'd1,
    ST_NOMATCH = 2'd2
  } status_t;

  typedef logic [13:0] freq_t;

  function automatic freq_t note_freq(input logic [6:0] n);
    freq_t t [128];
    t = '{
      0, 8, 9, 9, 10, 10, 11, 12, 12, 13, 14, 15,
      16, 17, 18, 19, 20, 21, 23, 24, 25, 27, 29, 30,
      32, 34, 36, 38, 41, 43, 46, 48, 51, 55, 58, 61,
      65, 69, 73, 77, 82, 87, 92, 97, 103, 110, 116, 123,
      130, 138, 146, 155, 164, 174, 184, 195, 207, 220, 233, 246,
      261, 277, 293, 311, 329, 349, 369, 391, 415, 440, 466, 493,
      523, 554, 587, 622, 659, 698, 739, 783, 830, 880, 932, 987,
      1046, 1108, 1174, 1244, 1318, 1396, 1479, 1567, 1661, 1760, 1864, 1975,
      2093, 2217, 2349, 2489, 2637, 2793, 2959, 3135, 3322, 3520, 3729, 3951,
      4186, 4434, 4698, 4978, 5274, 5587, 5919, 6271, 6644, 7040, 7458, 7902,
      8372, 8869, 9397, 9956, 10548, 11175, 11839, 12543};
    return t[n];
  endfunction

endpackage

### rtl/synth_voice_allocator_unit.sv
// ----------------------------------------------------------------------------
// synth_voice_allocator_unit: polyphonic voice table, oldest-note steal
// Each request word is accepted in the idle state only, so a new word is not
// taken until the result of the last one has been taken. A sequencer first
// scans the voice memory one entry per cycle through its single read port,
// whose read data is registered. Then come a write-back state for the chosen
// entry, a state presenting the result word until it is taken and the idle
// state in which the next word is accepted. Active and released flags sit in
// flip-flops and reset clears them at once. Records of inactive voices are
// never used, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module synth_voice_allocator_unit #(
  parameter int VOICES   = sva_pkg::VOICES_DEF,
  parameter int CHANNELS = sva_pkg::CHANNELS_DEF,
  parameter int MAX_VEL  = sva_pkg::MAX_VEL_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [7:0]  in_midi_channel,
  input  logic [7:0]  in_note_number,
  input  logic [7:0]  in_note_velocity,
  input  logic [31:0] in_now_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [3:0]  out_voice_index,
  output logic        out_was_stolen,
  output logic [13:0] out_frequency_hz,
  output logic [3:0]  out_active_count,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  import sva_pkg::*;

  localparam int AW = (VOICES > 1) ? $clog2(VOICES) : 1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_WRITE = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic [15:0] release_ms_r;
  logic [VOICES-1:0] act_r, rel_r;
  logic [1:0]  req_r;
  logic [7:0]  ch_r, note_r, vel_r;
  logic [31:0] now_r;
  logic [AW:0] rcnt_r;
  logic [AW:0] vcnt_r;
  logic        rvld_r;
  logic        found_r;
  logic [AW-1:0] sel_r;
  logic [31:0] best_r;
  logic [38:0] keep_r;
  logic [1:0]  status_r;
  logic [3:0]  vidx_r;
  logic        stolen_r;
  logic [13:0] freq_r;

  logic        we;
  logic [81:0] wdata, rdata;
  logic [AW-1:0] raddr, vi;
  logic [3:0]  r_ch;
  logic [6:0]  r_note;
  logic [31:0] r_start, r_rel;

  assign raddr = rcnt_r[AW-1:0];
  assign vi = vcnt_r[AW-1:0];
  assign {r_ch, r_note, r_start, r_rel} = {rdata[81:78], rdata[77:71], rdata[63:32],
                                           rdata[31:0]};

  sva_voice_mem #(.VOICES(VOICES), .AW(AW)) u_mem (
    .clk(clk), .we(we), .waddr(sel_r), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic [6:0] vel_c;
  assign vel_c = (vel_r > 8'(MAX_VEL)) ? 7'(MAX_VEL) : vel_r[6:0];
  assign we = (state_r == S_WRITE) &&
              ((req_r == REQ_NOTE_ON && status_r == ST_OK) ||
               (req_r == REQ_NOTE_OFF && found_r));
  assign wdata = (req_r == REQ_NOTE_ON) ? {ch_r[3:0], note_r[6:0], vel_c, now_r, 32'd0}
                                        : {ch_r[3:0], note_r[6:0], keep_r, now_r};

  logic bad_on;
  assign bad_on = (ch_r >= 8'(CHANNELS)) || note_r[7];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      release_ms_r <= RELEASE_MS_RST;
      act_r <= '0;
      rel_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        release_ms_r <= cfg_wdata;
      end
      if (state_r == S_WRITE) begin
        if (req_r == REQ_NOTE_ON && status_r == ST_OK) begin
          act_r[sel_r] <= 1'b1;
          rel_r[sel_r] <= 1'b0;
        end else if (req_r == REQ_NOTE_OFF && found_r) begin
          rel_r[sel_r] <= 1'b1;
        end else if (req_r == REQ_ALL_OFF) begin
          act_r <= '0;
          rel_r <= '0;
        end
      end
      if (state_r == S_SCAN && rvld_r && req_r == REQ_UPDATE && act_r[vi] && rel_r[vi]
          && (now_r - r_rel) >= {16'd0, release_ms_r}) begin
        act_r[vi] <= 1'b0;
        rel_r[vi] <= 1'b0;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_SCAN;
      S_SCAN:  if (rvld_r && vcnt_r == (AW+1)'(VOICES - 1)) state_nxt = S_WRITE;
      S_WRITE: state_nxt = S_OUT;
      S_OUT:   if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ready = (state_r == S_IDLE);

  logic [AW-1:0] free_idx;
  logic free_any;
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = VOICES - 1; i >= 0; i--) begin
      if (!act_r[i]) begin
        free_any = 1'b1;
        free_idx = AW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        req_r <= in_req_type;
        ch_r <= in_midi_channel;
        note_r <= in_note_number;
        vel_r <= in_note_velocity;
        now_r <= in_now_ms;
        rcnt_r <= '0;
        vcnt_r <= '0;
        rvld_r <= 1'b0;
        found_r <= 1'b0;
        sel_r <= '0;
      end
      S_SCAN: begin
        rcnt_r <= rcnt_r + 1'b1;
        rvld_r <= 1'b1;
        if (rvld_r) begin
          vcnt_r <= vcnt_r + 1'b1;
          if (req_r == REQ_NOTE_ON && (vcnt_r == '0 || r_start < best_r)) begin
            best_r <= r_start;
            sel_r <= vi;
          end
          if (req_r == REQ_NOTE_OFF && !found_r && act_r[vi] && {4'd0, r_ch} == ch_r
              && {1'b0, r_note} == note_r) begin
            found_r <= 1'b1;
            sel_r <= vi;
            keep_r <= rdata[70:32];
          end
        end
      end
      S_WRITE: ;
      default: ;
    endcase
    if (state_r == S_SCAN && state_nxt == S_WRITE) begin
      status_r <= ST_OK;
      vidx_r <= 4'(VOICES);
      stolen_r <= 1'b0;
      freq_r <= '0;
      if (req_r == REQ_NOTE_ON) begin
        if (bad_on) begin
          status_r <= ST_REJECT;
        end else begin
          freq_r <= note_freq(note_r[6:0]);
          stolen_r <= !free_any;
          if (free_any) begin
            sel_r <= free_idx;
            vidx_r <= 4'(free_idx);
          end else if (req_r == REQ_NOTE_ON && (r_start < best_r)) begin
            sel_r <= vi;
            vidx_r <= 4'(vi);
          end else begin
            vidx_r <= 4'(sel_r);
          end
        end
      end else if (req_r == REQ_NOTE_OFF) begin
        if (!found_r && act_r[vi] && {4'd0, r_ch} == ch_r && {1'b0, r_note} == note_r) begin
          found_r <= 1'b1;
          sel_r <= vi;
          keep_r <= rdata[70:32];
          vidx_r <= 4'(vi);
        end else if (found_r) begin
          vidx_r <= 4'(sel_r);
        end else begin
          status_r <= ST_NOMATCH;
        end
      end
    end
  end

  assign out_valid = (state_r == S_OUT);
  assign out_status = status_r;
  assign out_voice_index = vidx_r;
  assign out_was_stolen = stolen_r;
  assign out_frequency_hz = freq_r;
  assign out_active_count = 4'($countones(act_r));

  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid) else $error("ready while result pending");
  a_steal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_was_stolen) |-> (act_r == '1)) else $error("steal with free voice");
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("state not one-hot");
  a_rel: assert property (@(posedge clk) disable iff (!rst_n)
    (rel_r & ~act_r) == '0) else $error("released voice not active");
endmodule

### rtl/sva_voice_mem.sv
// ----------------------------------------------------------------------------
// sva_voice_mem: voice record memory
// One write port and one registered read port holding channel, note,
// velocity, start time and release time of each voice.
// ----------------------------------------------------------------------------
module sva_voice_mem #(
  parameter int VOICES = 8,
  parameter int AW = 3
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [81:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [81:0]   rdata
);
  logic [81:0] mem [VOICES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
